// File: src/i2cm_pkg.sv
package i2cm_pkg;

   localparam int DELAY_WIDTH   = 16;
   localparam int TIMEOUT_WIDTH = 24;

   // csr port
   localparam int CSR_ADDR_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = (TIMEOUT_WIDTH > DELAY_WIDTH) ? TIMEOUT_WIDTH : DELAY_WIDTH;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_HALF_PERIOD   = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_STRETCH_LIMIT = 1'b1;

   localparam logic [DELAY_WIDTH-1:0]   HALF_PERIOD_RESET   = DELAY_WIDTH'(250);
   localparam logic [TIMEOUT_WIDTH-1:0] STRETCH_LIMIT_RESET = TIMEOUT_WIDTH'(200000);

   localparam int BYTE_WIDTH = 8;

   // queue between front and back, depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   // one decoded tick as it travels through the queue
   typedef struct packed {
      logic                  cmd;
      logic                  op;
      logic                  start;
      logic                  stop;
      logic                  nack;
      logic [BYTE_WIDTH-1:0] shift_init;
      logic                  scl;
      logic                  sda;
   } item_type;

endpackage

// File: src/i2cm_front.sv
module i2cm_front import i2cm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd_valid,
   input  logic                  req_op,
   input  logic                  req_with_start,
   input  logic                  req_with_stop,
   input  logic [BYTE_WIDTH-1:0] req_tx_byte,
   input  logic                  req_master_nack,
   input  logic                  req_scl_in,
   input  logic                  req_sda_in,
   output item_type              q_item,
   output logic                  q_valid,
   input  logic                  q_pop
);

   item_type                 entry;
   item_type                 queue_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]     count_ff, count_in;
   logic                     push;

   // start is a write-only option; reads begin with an empty shift register
   always_comb begin
      entry.cmd        = req_cmd_valid;
      entry.op         = req_op;
      entry.start      = req_with_start & ~req_op;
      entry.stop       = req_with_stop;
      entry.nack       = req_master_nack;
      entry.shift_init = req_op ? '0 : req_tx_byte;
      entry.scl        = req_scl_in;
      entry.sda        = req_sda_in;
   end

   assign req_stall = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? PTR_WIDTH'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? PTR_WIDTH'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, q_pop})
         2'b10:   count_in = CNT_WIDTH'(count_ff + 1'b1);
         2'b01:   count_in = CNT_WIDTH'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: src/i2cm_back.sv
module i2cm_back import i2cm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  item_type                  q_item,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  logic                      csr_write,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_scl_release,
   output logic                      rsp_sda_release,
   output logic                      rsp_busy_res,
   output logic                      rsp_done_res,
   output logic [BYTE_WIDTH-1:0]     rsp_rx_byte,
   output logic                      rsp_slave_nack,
   output logic                      rsp_stretch_timeout
);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_RS_SDA  = 4'd1;
   localparam logic [3:0] PH_RS_SCL  = 4'd2;
   localparam logic [3:0] PH_RS_HOLD = 4'd3;
   localparam logic [3:0] PH_ST_SDA  = 4'd4;
   localparam logic [3:0] PH_WB_SET  = 4'd5;
   localparam logic [3:0] PH_WB_SCL  = 4'd6;
   localparam logic [3:0] PH_WB_WAIT = 4'd7;
   localparam logic [3:0] PH_RB_REL  = 4'd8;
   localparam logic [3:0] PH_RB_WAIT = 4'd9;
   localparam logic [3:0] PH_RB_HOLD = 4'd10;
   localparam logic [3:0] PH_SP_SDA  = 4'd11;
   localparam logic [3:0] PH_SP_SCL  = 4'd12;
   localparam logic [3:0] PH_SP_HOLD = 4'd13;
   localparam logic [3:0] PH_SP_REL  = 4'd14;

   localparam logic [3:0] BYTE_BITS = 4'(BYTE_WIDTH);

   // cmd latch bit positions
   localparam int LATCH_OP   = 0;
   localparam int LATCH_STOP = 1;
   localparam int LATCH_NACK = 2;

   // data bits go in the direction of the command, the ack bit the other way
   function automatic logic [3:0] bit_phase(input logic op, input logic [3:0] bit_idx);
      logic is_ack;
      is_ack = (bit_idx >= BYTE_BITS);
      return (op == is_ack) ? PH_WB_SET : PH_RB_REL;
   endfunction

   logic [DELAY_WIDTH-1:0]   half_period_ff;
   logic [TIMEOUT_WIDTH-1:0] stretch_limit_ff;

   logic [3:0]               phase_ff, phase_in;
   logic [DELAY_WIDTH-1:0]   delay_count_ff, delay_count_in;
   logic [TIMEOUT_WIDTH-1:0] stretch_count_ff, stretch_count_in;
   logic [3:0]               bit_index_ff, bit_index_in;
   logic [BYTE_WIDTH-1:0]    shift_reg_ff, shift_reg_in;
   logic                     bus_started_ff, bus_started_in;
   logic [2:0]               cmd_latch_ff, cmd_latch_in;
   logic                     timeout_seen_ff, timeout_seen_in;
   logic                     scl_line_ff, scl_line_in;
   logic                     sda_line_ff, sda_line_in;
   logic                     ack_bit_ff, ack_bit_in;

   logic                     rsp_valid_ff;
   logic                     rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff;
   logic [BYTE_WIDTH-1:0]    rsp_rx_byte_ff;
   logic                     rsp_slave_nack_ff, rsp_timeout_ff;

   logic                     advance;
   logic                     done_now;
   logic                     do_enter;
   logic [3:0]               target;
   logic [DELAY_WIDTH-1:0]   dc_inc;
   logic [TIMEOUT_WIDTH-1:0] sc_inc;
   logic                     delay_hit;
   logic                     stretch_hit;
   logic                     wait_hit;

   // the output register frees up when empty or when its transaction is taken
   assign advance = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign q_pop   = advance;

   always_comb begin
      phase_in         = phase_ff;
      delay_count_in   = delay_count_ff;
      stretch_count_in = stretch_count_ff;
      bit_index_in     = bit_index_ff;
      shift_reg_in     = shift_reg_ff;
      bus_started_in   = bus_started_ff;
      cmd_latch_in     = cmd_latch_ff;
      timeout_seen_in  = timeout_seen_ff;
      scl_line_in      = scl_line_ff;
      sda_line_in      = sda_line_ff;
      ack_bit_in       = ack_bit_ff;
      done_now         = 1'b0;
      do_enter         = 1'b0;
      target           = PH_IDLE;

      dc_inc      = DELAY_WIDTH'(delay_count_ff + 1'b1);
      sc_inc      = TIMEOUT_WIDTH'(stretch_count_ff + 1'b1);
      delay_hit   = (half_period_ff == '0) || (dc_inc >= half_period_ff);
      stretch_hit = (stretch_limit_ff == '0) || (sc_inc >= stretch_limit_ff);
      wait_hit    = q_item.scl | stretch_hit;

      unique case (phase_ff)
         PH_IDLE: begin
            if (q_item.cmd) begin
               cmd_latch_in    = {q_item.nack, q_item.stop, q_item.op};
               timeout_seen_in = 1'b0;
               ack_bit_in      = 1'b0;
               bit_index_in    = '0;
               shift_reg_in    = q_item.shift_init;
               do_enter        = 1'b1;
               if (q_item.start) begin
                  target = bus_started_ff ? PH_RS_SDA : PH_ST_SDA;
               end else begin
                  target = bit_phase(q_item.op, 4'd0);
               end
            end
         end
         PH_RS_SDA, PH_RS_HOLD, PH_WB_SET, PH_WB_SCL, PH_RB_REL, PH_SP_SDA,
         PH_SP_HOLD: begin
            delay_count_in = dc_inc;
            if (delay_hit) begin
               do_enter = 1'b1;
               unique case (phase_ff)
                  PH_RS_SDA:  target = PH_RS_SCL;
                  PH_RS_HOLD: target = PH_ST_SDA;
                  PH_WB_SET:  target = PH_WB_SCL;
                  PH_WB_SCL:  target = PH_WB_WAIT;
                  PH_RB_REL:  target = PH_RB_WAIT;
                  PH_SP_SDA:  target = PH_SP_SCL;
                  default:    target = PH_SP_REL;
               endcase
            end
         end
         PH_RS_SCL, PH_RB_WAIT, PH_SP_SCL: begin
            if (!q_item.scl) begin
               stretch_count_in = sc_inc;
               if (stretch_hit) begin
                  timeout_seen_in = 1'b1;
               end
            end
            if (wait_hit) begin
               do_enter = 1'b1;
               unique case (phase_ff)
                  PH_RS_SCL:  target = PH_RS_HOLD;
                  PH_RB_WAIT: target = PH_RB_HOLD;
                  default:    target = PH_SP_HOLD;
               endcase
            end
         end
         PH_ST_SDA: begin
            delay_count_in = dc_inc;
            if (delay_hit) begin
               scl_line_in    = 1'b0;
               bus_started_in = 1'b1;
               do_enter       = 1'b1;
               target         = bit_phase(cmd_latch_ff[LATCH_OP], bit_index_ff);
            end
         end
         PH_WB_WAIT, PH_RB_HOLD: begin
            if (phase_ff == PH_WB_WAIT) begin
               if (!q_item.scl) begin
                  stretch_count_in = sc_inc;
                  if (stretch_hit) begin
                     timeout_seen_in = 1'b1;
                  end
               end
            end else begin
               delay_count_in = dc_inc;
            end
            if ((phase_ff == PH_WB_WAIT) ? wait_hit : delay_hit) begin
               if (bit_index_ff < BYTE_BITS) begin
                  shift_reg_in = (phase_ff == PH_WB_WAIT) ?
                                 {shift_reg_ff[BYTE_WIDTH-2:0], 1'b0} :
                                 {shift_reg_ff[BYTE_WIDTH-2:0], q_item.sda};
               end else if (phase_ff == PH_RB_HOLD) begin
                  ack_bit_in = q_item.sda;
               end
               scl_line_in  = 1'b0;
               bit_index_in = 4'(bit_index_ff + 1'b1);
               // past the ack bit: stop or finish
               if (bit_index_in > BYTE_BITS) begin
                  if (cmd_latch_ff[LATCH_STOP]) begin
                     do_enter = 1'b1;
                     target   = PH_SP_SDA;
                  end else begin
                     phase_in = PH_IDLE;
                     done_now = 1'b1;
                  end
               end else begin
                  do_enter = 1'b1;
                  target   = bit_phase(cmd_latch_ff[LATCH_OP], bit_index_in);
               end
            end
         end
         PH_SP_REL: begin
            delay_count_in = dc_inc;
            if (delay_hit) begin
               bus_started_in = 1'b0;
               phase_in       = PH_IDLE;
               done_now       = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // phase entry resets both timers and, for a phase that owns a line, sets that line
      if (do_enter) begin
         phase_in         = target;
         delay_count_in   = '0;
         stretch_count_in = '0;
         unique case (target)
            PH_RS_SDA, PH_RB_REL, PH_SP_REL:            sda_line_in = 1'b1;
            PH_RS_SCL, PH_WB_SCL, PH_RB_WAIT, PH_SP_SCL: scl_line_in = 1'b1;
            PH_ST_SDA, PH_SP_SDA:                       sda_line_in = 1'b0;
            PH_WB_SET: begin
               sda_line_in = (bit_index_in < BYTE_BITS) ? shift_reg_in[BYTE_WIDTH-1] :
                                                          cmd_latch_in[LATCH_NACK];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= HALF_PERIOD_RESET;
         stretch_limit_ff <= STRETCH_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_addr)
            CSR_HALF_PERIOD:   half_period_ff   <= csr_wdata[DELAY_WIDTH-1:0];
            CSR_STRETCH_LIMIT: stretch_limit_ff <= csr_wdata[TIMEOUT_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         delay_count_ff   <= '0;
         stretch_count_ff <= '0;
         bit_index_ff     <= '0;
         shift_reg_ff     <= '0;
         bus_started_ff   <= 1'b0;
         cmd_latch_ff     <= '0;
         timeout_seen_ff  <= 1'b0;
         scl_line_ff      <= 1'b1;
         sda_line_ff      <= 1'b1;
         ack_bit_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff         <= phase_in;
            delay_count_ff   <= delay_count_in;
            stretch_count_ff <= stretch_count_in;
            bit_index_ff     <= bit_index_in;
            shift_reg_ff     <= shift_reg_in;
            bus_started_ff   <= bus_started_in;
            cmd_latch_ff     <= cmd_latch_in;
            timeout_seen_ff  <= timeout_seen_in;
            scl_line_ff      <= scl_line_in;
            sda_line_ff      <= sda_line_in;
            ack_bit_ff       <= ack_bit_in;
            rsp_valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_scl_ff        <= scl_line_in;
         rsp_sda_ff        <= sda_line_in;
         rsp_busy_ff       <= (phase_in != PH_IDLE);
         rsp_done_ff       <= done_now;
         rsp_rx_byte_ff    <= (done_now && cmd_latch_in[LATCH_OP]) ? shift_reg_in : '0;
         rsp_slave_nack_ff <= done_now & ~cmd_latch_in[LATCH_OP] & ack_bit_in;
         rsp_timeout_ff    <= done_now & timeout_seen_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scl_release     = rsp_scl_ff;
   assign rsp_sda_release     = rsp_sda_ff;
   assign rsp_busy_res        = rsp_busy_ff;
   assign rsp_done_res        = rsp_done_ff;
   assign rsp_rx_byte         = rsp_rx_byte_ff;
   assign rsp_slave_nack      = rsp_slave_nack_ff;
   assign rsp_stretch_timeout = rsp_timeout_ff;

endmodule

// File: src/i2c_master_byte_engine_core.sv
// a taken tick passes through the queue and then the sequencer's output register before its result is offered
// throughput: one tick per cycle while the queue has room; the sequencer steps once for each queued tick
// a four-entry queue in front of the sequencer absorbs result-side stalls
// reset: queue empty, sequencer idle, both lines released, bus not started,
// half period 250 ticks, stretch limit 200000 ticks
module i2c_master_byte_engine_core import i2cm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd_valid,
   input  logic                      req_op,
   input  logic                      req_with_start,
   input  logic                      req_with_stop,
   input  logic [BYTE_WIDTH-1:0]     req_tx_byte,
   input  logic                      req_master_nack,
   input  logic                      req_scl_in,
   input  logic                      req_sda_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_scl_release,
   output logic                      rsp_sda_release,
   output logic                      rsp_busy_res,
   output logic                      rsp_done_res,
   output logic [BYTE_WIDTH-1:0]     rsp_rx_byte,
   output logic                      rsp_slave_nack,
   output logic                      rsp_stretch_timeout,
   input  logic                      csr_write,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   i2cm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd_valid   (req_cmd_valid),
      .req_op          (req_op),
      .req_with_start  (req_with_start),
      .req_with_stop   (req_with_stop),
      .req_tx_byte     (req_tx_byte),
      .req_master_nack (req_master_nack),
      .req_scl_in      (req_scl_in),
      .req_sda_in      (req_sda_in),
      .q_item          (q_item),
      .q_valid         (q_valid),
      .q_pop           (q_pop)
   );

   i2cm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_item              (q_item),
      .q_valid             (q_valid),
      .q_pop               (q_pop),
      .csr_write           (csr_write),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scl_release     (rsp_scl_release),
      .rsp_sda_release     (rsp_sda_release),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_done_res        (rsp_done_res),
      .rsp_rx_byte         (rsp_rx_byte),
      .rsp_slave_nack      (rsp_slave_nack),
      .rsp_stretch_timeout (rsp_stretch_timeout)
   );

   // a completing transaction leaves the sequencer idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // result fields only carry data on completion
   a_fields_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         rsp_rx_byte == '0 && !rsp_slave_nack && !rsp_stretch_timeout)
      else $error("result fields set without done");

   // a read never reports a slave nack and a write never returns data
   a_read_or_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_slave_nack |-> rsp_rx_byte == '0)
      else $error("slave nack together with received data");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("transaction offered right after reset");

endmodule

// File: tb/tb_i2c_master_byte_engine_core.sv
module tb_i2c_master_byte_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cm_pkg::*;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   localparam int QUIET_LIMIT = 1000;

   typedef enum logic [4:0] {
      IDLE, RSTART_SDA, RSTART_SCL, RSTART_HOLD, START_SDA,
      WBIT_SET, WBIT_SCL, WBIT_WAIT, RBIT_REL, RBIT_WAIT, RBIT_HOLD,
      STOP_SDA, STOP_SCL, STOP_HOLD, STOP_REL
   } seq_phase_type;

   typedef struct packed {
      logic                  cmd;
      logic                  op;
      logic                  start;
      logic                  stop;
      logic [BYTE_WIDTH-1:0] tx;
      logic                  nack;
      logic                  scl;
      logic                  sda;
   } tick_type;

   typedef struct packed {
      logic                  scl;
      logic                  sda;
      logic                  busy;
      logic                  done;
      logic [BYTE_WIDTH-1:0] rx;
      logic                  nack;
      logic                  tmo;
   } bus_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_cmd_valid;
   logic                      req_op;
   logic                      req_with_start;
   logic                      req_with_stop;
   logic [BYTE_WIDTH-1:0]     req_tx_byte;
   logic                      req_master_nack;
   logic                      req_scl_in;
   logic                      req_sda_in;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_scl_release;
   logic                      rsp_sda_release;
   logic                      rsp_busy_res;
   logic                      rsp_done_res;
   logic [BYTE_WIDTH-1:0]     rsp_rx_byte;
   logic                      rsp_slave_nack;
   logic                      rsp_stretch_timeout;
   logic                      csr_write;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   i2c_master_byte_engine_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd_valid       (req_cmd_valid),
      .req_op              (req_op),
      .req_with_start      (req_with_start),
      .req_with_stop       (req_with_stop),
      .req_tx_byte         (req_tx_byte),
      .req_master_nack     (req_master_nack),
      .req_scl_in          (req_scl_in),
      .req_sda_in          (req_sda_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scl_release     (rsp_scl_release),
      .rsp_sda_release     (rsp_sda_release),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_done_res        (rsp_done_res),
      .rsp_rx_byte         (rsp_rx_byte),
      .rsp_slave_nack      (rsp_slave_nack),
      .rsp_stretch_timeout (rsp_stretch_timeout),
      .csr_write           (csr_write),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata)
   );

   // engine state as predicted
   logic [DELAY_WIDTH-1:0]   half_period;
   logic [TIMEOUT_WIDTH-1:0] stretch_limit;
   seq_phase_type            phase;
   logic [DELAY_WIDTH-1:0]   delay_cnt;
   logic [TIMEOUT_WIDTH-1:0] stretch_cnt;
   logic [3:0]               bit_idx;
   logic [BYTE_WIDTH-1:0]    shifter;
   logic                     bus_held;
   logic                     lat_op;
   logic                     lat_stop;
   logic                     lat_nack;
   logic                     timed_out;
   logic                     scl_rel;
   logic                     sda_rel;
   logic                     ack_seen;
   logic                     done_tick;

   bus_result_type pending_q[$];
   int             mismatches;
   int             results_seen;
   int             ticks_sent;
   int             quiet_cycles;
   int             stall_left;
   bit             gaps_on;
   bit             stalls_on;

   // slave side of the bus
   int hold_left;
   int hold_pct;
   int hold_max;
   int sda_mode;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void enter_phase(seq_phase_type p);
      phase       = p;
      delay_cnt   = '0;
      stretch_cnt = '0;
      case (p)
         RSTART_SDA, RBIT_REL, STOP_REL: sda_rel = 1'b1;
         RSTART_SCL, WBIT_SCL, RBIT_WAIT, STOP_SCL: scl_rel = 1'b1;
         START_SDA, STOP_SDA: sda_rel = 1'b0;
         WBIT_SET: sda_rel = (bit_idx < 8) ? shifter[7] : lat_nack;
         default: ;
      endcase
   endfunction

   // data bits of a write and the ack of a read are driven by the master
   function automatic void next_bit();
      if (lat_op == (bit_idx >= 8)) enter_phase(WBIT_SET);
      else enter_phase(RBIT_REL);
   endfunction

   function automatic void bit_end();
      bit_idx = bit_idx + 1'b1;
      if (bit_idx >= 9) begin
         if (lat_stop) begin
            enter_phase(STOP_SDA);
         end else begin
            phase     = IDLE;
            done_tick = 1'b1;
         end
      end else begin
         next_bit();
      end
   endfunction

   function automatic bit delay_elapsed();
      delay_cnt = delay_cnt + 1'b1;
      return (half_period == 0) || (delay_cnt >= half_period);
   endfunction

   function automatic bit scl_up(logic scl);
      if (scl) return 1'b1;
      stretch_cnt = stretch_cnt + 1'b1;
      if (stretch_limit == 0 || stretch_cnt >= stretch_limit) begin
         timed_out = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bus_result_type engine_step(tick_type t);
      bus_result_type r;
      done_tick = 1'b0;
      case (phase)
         IDLE: if (t.cmd) begin
            lat_op    = t.op;
            lat_stop  = t.stop;
            lat_nack  = t.nack;
            timed_out = 1'b0;
            ack_seen  = 1'b0;
            bit_idx   = '0;
            shifter   = (t.op == OP_READ) ? '0 : t.tx;
            if (t.op == OP_WRITE && t.start) begin
               if (bus_held) enter_phase(RSTART_SDA);
               else enter_phase(START_SDA);
            end else begin
               next_bit();
            end
         end
         RSTART_SDA: if (delay_elapsed()) enter_phase(RSTART_SCL);
         RSTART_SCL: if (scl_up(t.scl)) enter_phase(RSTART_HOLD);
         RSTART_HOLD: if (delay_elapsed()) enter_phase(START_SDA);
         START_SDA: if (delay_elapsed()) begin
            scl_rel  = 1'b0;
            bus_held = 1'b1;
            next_bit();
         end
         WBIT_SET: if (delay_elapsed()) enter_phase(WBIT_SCL);
         WBIT_SCL: if (delay_elapsed()) enter_phase(WBIT_WAIT);
         WBIT_WAIT: if (scl_up(t.scl)) begin
            scl_rel = 1'b0;
            if (bit_idx < 8) shifter = {shifter[6:0], 1'b0};
            bit_end();
         end
         RBIT_REL: if (delay_elapsed()) enter_phase(RBIT_WAIT);
         RBIT_WAIT: if (scl_up(t.scl)) enter_phase(RBIT_HOLD);
         RBIT_HOLD: if (delay_elapsed()) begin
            if (bit_idx < 8) shifter = {shifter[6:0], t.sda};
            else ack_seen = t.sda;
            scl_rel = 1'b0;
            bit_end();
         end
         STOP_SDA: if (delay_elapsed()) enter_phase(STOP_SCL);
         STOP_SCL: if (scl_up(t.scl)) enter_phase(STOP_HOLD);
         STOP_HOLD: if (delay_elapsed()) enter_phase(STOP_REL);
         STOP_REL: if (delay_elapsed()) begin
            bus_held  = 1'b0;
            phase     = IDLE;
            done_tick = 1'b1;
         end
         default: phase = IDLE;
      endcase
      r.scl  = scl_rel;
      r.sda  = sda_rel;
      r.busy = (phase != IDLE);
      r.done = done_tick;
      r.rx   = (done_tick && lat_op == OP_READ) ? shifter : '0;
      r.nack = (done_tick && lat_op == OP_WRITE) ? ack_seen : 1'b0;
      r.tmo  = done_tick ? timed_out : 1'b0;
      return r;
   endfunction

   // pin levels for the next tick, with random clock stretching by the slave
   function automatic tick_type line_tick();
      tick_type t;
      t.cmd   = 1'b0;
      t.op    = 1'($urandom_range(0, 1));
      t.start = 1'($urandom_range(0, 1));
      t.stop  = 1'($urandom_range(0, 1));
      t.tx    = 8'($urandom);
      t.nack  = 1'($urandom_range(0, 1));
      if (hold_left > 0) begin
         t.scl = 1'b0;
         hold_left--;
      end else if ($urandom_range(1, 100) <= hold_pct) begin
         t.scl     = 1'b0;
         hold_left = $urandom_range(0, hold_max - 1);
      end else begin
         t.scl = scl_rel;
      end
      case (sda_mode)
         SDA_LOW: t.sda = 1'b0;
         SDA_HIGH: t.sda = 1'b1;
         default: t.sda = 1'($urandom_range(0, 1));
      endcase
      // commands offered mid-transfer must be dropped
      if (phase != IDLE && $urandom_range(0, 7) == 0) t.cmd = 1'b1;
      return t;
   endfunction

   task automatic send_tick(tick_type t);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd_valid   <= t.cmd;
      req_op          <= t.op;
      req_with_start  <= t.start;
      req_with_stop   <= t.stop;
      req_tx_byte     <= t.tx;
      req_master_nack <= t.nack;
      req_scl_in      <= t.scl;
      req_sda_in      <= t.sda;
      do @(posedge clock); while (req_stall);
      pending_q.push_back(engine_step(t));
      ticks_sent++;
   endtask

   task automatic run_command(logic op, logic start, logic stop, logic [7:0] data,
                              logic nack);
      tick_type t;
      t       = line_tick();
      t.cmd   = 1'b1;
      t.op    = op;
      t.start = start;
      t.stop  = stop;
      t.tx    = data;
      t.nack  = nack;
      send_tick(t);
      while (phase != IDLE) send_tick(line_tick());
   endtask

   // stop sending and let every result come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      settle();
      csr_write <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_HALF_PERIOD) half_period = value[DELAY_WIDTH-1:0];
      else stretch_limit = value[TIMEOUT_WIDTH-1:0];
   endtask

   task automatic test_reset_defaults();
      tick_type t;
      hold_pct = 0;
      sda_mode = SDA_RANDOM;
      t       = line_tick();
      t.cmd   = 1'b1;
      t.op    = OP_WRITE;
      t.start = 1'b0;
      t.stop  = 1'b0;
      t.tx    = 8'hA5;
      t.nack  = 1'b0;
      send_tick(t);
      // past the first half period at the reset value, then shorten it mid-command
      repeat (260) send_tick(line_tick());
      write_reg(CSR_HALF_PERIOD, 1);
      while (phase != IDLE) send_tick(line_tick());
   endtask

   task automatic test_bus_sequences();
      write_reg(CSR_HALF_PERIOD, 1);
      write_reg(CSR_STRETCH_LIMIT, 24'hFFFFFF);
      sda_mode = SDA_LOW;
      run_command(OP_WRITE, 1'b1, 1'b0, 8'hFF, 1'b0);
      // start while the bus is held gives a repeated start
      sda_mode = SDA_HIGH;
      run_command(OP_WRITE, 1'b1, 1'b1, 8'h00, 1'b1);
      // start flag on a read is ignored
      run_command(OP_READ, 1'b1, 1'b0, 8'h5A, 1'b0);
      sda_mode = SDA_LOW;
      run_command(OP_READ, 1'b0, 1'b1, 8'hFF, 1'b1);
      // byte and stop with no start before them
      sda_mode = SDA_RANDOM;
      run_command(OP_WRITE, 1'b0, 1'b1, 8'h96, 1'b0);
   endtask

   task automatic test_register_edges();
      write_reg(CSR_HALF_PERIOD, 0);
      run_command(OP_WRITE, 1'b1, 1'b1, 8'h3C, 1'b0);
      // upper data bits fall outside the delay register
      write_reg(CSR_HALF_PERIOD, 24'hFF0002);
      run_command(OP_READ, 1'b0, 1'b1, 8'h00, 1'b0);
   endtask

   task automatic test_stretch_timeouts();
      write_reg(CSR_HALF_PERIOD, 1);
      write_reg(CSR_STRETCH_LIMIT, 0);
      hold_pct = 40;
      hold_max = 3;
      run_command(OP_WRITE, 1'b1, 1'b0, 8'hC3, 1'b0);
      write_reg(CSR_STRETCH_LIMIT, 3);
      hold_pct = 50;
      hold_max = 8;
      run_command(OP_WRITE, 1'b1, 1'b1, 8'h81, 1'b0);
      write_reg(CSR_STRETCH_LIMIT, 1);
      run_command(OP_READ, 1'b0, 1'b1, 8'h00, 1'b1);
      hold_pct = 0;
   endtask

   task automatic test_random_traffic();
      int seg;
      int target;
      for (seg = 0; seg < 4; seg++) begin
         gaps_on   = (seg < 2);
         stalls_on = (seg == 0 || seg == 2);
         write_reg(CSR_HALF_PERIOD, CSR_DATA_WIDTH'($urandom_range(0, 3)));
         case ($urandom_range(0, 2))
            0: write_reg(CSR_STRETCH_LIMIT, CSR_DATA_WIDTH'($urandom_range(0, 4)));
            1: write_reg(CSR_STRETCH_LIMIT, CSR_DATA_WIDTH'($urandom_range(5, 30)));
            default: write_reg(CSR_STRETCH_LIMIT, 24'hFFFFFF);
         endcase
         hold_pct = $urandom_range(0, 30);
         hold_max = $urandom_range(1, 8);
         target   = ticks_sent + 200;
         while (ticks_sent < target) begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) send_tick(line_tick());
            sda_mode = $urandom_range(0, 3) == 0 ? $urandom_range(SDA_LOW, SDA_HIGH) : SDA_RANDOM;
            run_command(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_long_delay();
      tick_type t;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_reg(CSR_HALF_PERIOD, 24'h00FFFF);
      write_reg(CSR_STRETCH_LIMIT, 24'hFFFFFF);
      hold_pct = 0;
      sda_mode = SDA_RANDOM;
      t       = line_tick();
      t.cmd   = 1'b1;
      t.op    = OP_WRITE;
      t.start = 1'b0;
      t.tx    = 8'h80;
      send_tick(t);
      // the first bit holds its data during the maximum half period, which outlasts the ticks sent here
      repeat (200) send_tick(line_tick());
   endtask

   // receiver backpressure in random bursts
   always @(posedge clock) begin
      if (!stalls_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      bus_result_type got;
      bus_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.scl  = rsp_scl_release;
         got.sda  = rsp_sda_release;
         got.busy = rsp_busy_res;
         got.done = rsp_done_res;
         got.rx   = rsp_rx_byte;
         got.nack = rsp_slave_nack;
         got.tmo  = rsp_stretch_timeout;
         results_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with no transaction pending", results_seen);
         end else begin
            want = pending_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0d: expected scl %b sda %b busy %b done %b rx %h nack %b",
                            " tmo %b, got scl %b sda %b busy %b done %b rx %h nack %b tmo %b"},
                           results_seen, want.scl, want.sda, want.busy, want.done, want.rx,
                           want.nack, want.tmo, got.scl, got.sda, got.busy, got.done, got.rx,
                           got.nack, got.tmo);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("i2c_master_byte_engine_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_cmd_valid   <= 1'b0;
      req_op          <= 1'b0;
      req_with_start  <= 1'b0;
      req_with_stop   <= 1'b0;
      req_tx_byte     <= '0;
      req_master_nack <= 1'b0;
      req_scl_in      <= 1'b1;
      req_sda_in      <= 1'b1;
      rsp_stall       <= 1'b0;
      csr_write       <= 1'b0;
      csr_addr        <= CSR_HALF_PERIOD;
      csr_wdata       <= '0;
      half_period     = HALF_PERIOD_RESET;
      stretch_limit   = STRETCH_LIMIT_RESET;
      phase           = IDLE;
      delay_cnt       = '0;
      stretch_cnt     = '0;
      bit_idx         = '0;
      shifter         = '0;
      bus_held        = 1'b0;
      lat_op          = 1'b0;
      lat_stop        = 1'b0;
      lat_nack        = 1'b0;
      timed_out       = 1'b0;
      scl_rel         = 1'b1;
      sda_rel         = 1'b1;
      ack_seen        = 1'b0;
      done_tick       = 1'b0;
      mismatches      = 0;
      results_seen    = 0;
      ticks_sent      = 0;
      quiet_cycles    = 0;
      stall_left      = 0;
      hold_left       = 0;
      hold_pct        = 0;
      hold_max        = 1;
      sda_mode        = SDA_RANDOM;
      gaps_on         = 1'b1;
      stalls_on       = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_bus_sequences();
      test_register_edges();
      test_stretch_timeouts();
      test_random_traffic();
      test_long_delay();

      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("i2c_master_byte_engine_core test passed");
      end else begin
         $display("i2c_master_byte_engine_core test failed");
      end
      $finish;
   end

endmodule
